>>> design/rcpd_pkg.sv
`timescale 1ns / 1ps

package rcpd_pkg;

   localparam int KW  = 14;
   localparam int XW  = 8;
   localparam int SW  = 8;
   localparam int HW  = 5;
   localparam int WW  = 4;
   localparam int DW  = 7;
   localparam int AW  = 16;
   localparam int QW  = 7;
   localparam int CW  = 4;

   typedef struct packed {
      logic          start;
      logic [KW-1:0] dividend;
      logic [DW-1:0] divisor;
   } rcpd_div_req_type;

   typedef struct packed {
      logic          done;
      logic [DW-1:0] remainder;
   } rcpd_div_rsp_type;

   // C(h, ceil(h/2)) for h = 0..16
   function automatic logic [KW-1:0] central_binom(input logic [HW-1:0] h);
      logic [KW-1:0] v;
      case (h)
         5'd0:    v = 14'd1;
         5'd1:    v = 14'd1;
         5'd2:    v = 14'd2;
         5'd3:    v = 14'd3;
         5'd4:    v = 14'd6;
         5'd5:    v = 14'd10;
         5'd6:    v = 14'd20;
         5'd7:    v = 14'd35;
         5'd8:    v = 14'd70;
         5'd9:    v = 14'd126;
         5'd10:   v = 14'd252;
         5'd11:   v = 14'd462;
         5'd12:   v = 14'd924;
         5'd13:   v = 14'd1716;
         5'd14:   v = 14'd3432;
         5'd15:   v = 14'd6435;
         5'd16:   v = 14'd12870;
         default: v = '1;
      endcase
      return v;
   endfunction

endpackage

>>> design/rcpd_rem_unit.sv
`timescale 1ns / 1ps

module rcpd_rem_unit
   import rcpd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  rcpd_div_req_type div_req,
   output rcpd_div_rsp_type div_rsp
);

   localparam logic [CW-1:0] LastStep = CW'(KW - 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [KW-1:0] sh_ff, sh_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [DW:0]   trial;

   // restoring division, one dividend bit per cycle, remainder only
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, sh_ff[KW-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sh_in   = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DW'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[DW-1:0];
         end
         sh_in  = {sh_ff[KW-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

>>> design/raptor_code_parameter_derivation_core.sv
`timescale 1ns / 1ps
// Raptor systematic parameter derivation.
// req channel: req_valid / req_stall / req_source_count (K). An item is
// taken when req_valid is high and req_stall low; req_stall stays high
// from the cycle after acceptance until the sequencer is back in idle.
// K above MAX_SOURCE is clamped to MAX_SOURCE.
// rsp channel: rsp_valid / rsp_stall plus X, S, H, ceil(H/2), L and L'.
// Results sit in an output register; a new item may be accepted while the
// previous result is still stalled, but the sequencer holds its finished
// result until that register frees up.
// Steps in order: X search, ceiling of K/100 by repeated adds, prime
// search for S, H search (one cycle per H step, at most 17 steps) and
// prime search for L'; each trial divisor uses the remainder unit plus
// a check. The sequencer works on one item at a time.
// Reset (synchronous, active high) returns the sequencer to idle and
// drops rsp_valid; no clearing pass is needed.

module raptor_code_parameter_derivation_core
   import rcpd_pkg::*;
#(
   parameter int unsigned MAX_SOURCE = 8192
)(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [KW-1:0] req_source_count,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [XW-1:0] rsp_x_value,
   output logic [SW-1:0] rsp_ldpc_count,
   output logic [HW-1:0] rsp_half_count,
   output logic [WW-1:0] rsp_half_weight,
   output logic [KW-1:0] rsp_intermediate_count,
   output logic [KW-1:0] rsp_intermediate_prime
);

   localparam logic [KW-1:0] MaxK = KW'(MAX_SOURCE);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_X    = 4'd1;
   localparam logic [3:0] ST_Q    = 4'd2;
   localparam logic [3:0] ST_QX   = 4'd3;
   localparam logic [3:0] ST_CHK  = 4'd4;
   localparam logic [3:0] ST_DIV  = 4'd5;
   localparam logic [3:0] ST_H    = 4'd6;
   localparam logic [3:0] ST_LS   = 4'd7;
   localparam logic [3:0] ST_DONE = 4'd8;

   localparam logic [KW-1:0] FirstSq  = 14'd4;
   localparam logic [DW-1:0] FirstDiv = 7'd2;
   localparam logic [AW-1:0] Hundred  = 16'd100;

   logic [3:0]    state_ff, state_in;
   logic [KW-1:0] k_ff, k_in;
   logic [XW-1:0] x_ff, x_in;
   logic [AW-1:0] p_ff, p_in;
   logic [QW-1:0] q_ff, q_in;
   logic [KW-1:0] m_ff, m_in;
   logic [KW-1:0] n_ff, n_in;
   logic [DW-1:0] d_ff, d_in;
   logic [KW-1:0] sq_ff, sq_in;
   logic          tgt_ff, tgt_in;
   logic [SW-1:0] s_ff, s_in;
   logic [HW-1:0] h_ff, h_in;
   logic [KW-1:0] l_ff, l_in;

   logic          ov_ff, ov_in;
   logic [XW-1:0] ox_ff, ox_in;
   logic [SW-1:0] os_ff, os_in;
   logic [HW-1:0] oh_ff, oh_in;
   logic [WW-1:0] ow_ff, ow_in;
   logic [KW-1:0] ol_ff, ol_in;
   logic [KW-1:0] olp_ff, olp_in;

   logic [AW-1:0] add_a, add_b, add_sum;
   logic [HW:0]   h_inc;

   rcpd_div_req_type div_req;
   rcpd_div_rsp_type div_rsp;

   rcpd_rem_unit u_rem (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // shared adder, operands picked by the sequencer
   assign add_sum = add_a + add_b;
   assign h_inc   = {1'b0, h_ff} + 1'b1;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      x_in     = x_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      m_in     = m_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      sq_in    = sq_ff;
      tgt_in   = tgt_ff;
      s_in     = s_ff;
      h_in     = h_ff;
      l_in     = l_ff;
      ov_in    = ov_ff && rsp_stall;
      ox_in    = ox_ff;
      os_in    = os_ff;
      oh_in    = oh_ff;
      ow_in    = ow_ff;
      ol_in    = ol_ff;
      olp_in   = olp_ff;
      add_a    = '0;
      add_b    = '0;
      div_req.start    = 1'b0;
      div_req.dividend = n_ff;
      div_req.divisor  = d_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               k_in     = (req_source_count > MaxK) ? MaxK : req_source_count;
               x_in     = '0;
               p_in     = '0;
               state_in = ST_X;
            end
         end
         ST_X: begin
            add_a = p_ff;
            add_b = AW'({x_ff, 1'b0});
            if (p_ff >= AW'({k_ff, 1'b0})) begin
               q_in     = '0;
               m_in     = '0;
               state_in = ST_Q;
            end else begin
               p_in = add_sum;
               x_in = x_ff + 1'b1;
            end
         end
         ST_Q: begin
            add_a = AW'(m_ff);
            add_b = Hundred;
            if (m_ff >= k_ff) begin
               state_in = ST_QX;
            end else begin
               m_in = add_sum[KW-1:0];
               q_in = q_ff + 1'b1;
            end
         end
         ST_QX: begin
            add_a    = AW'(q_ff);
            add_b    = AW'(x_ff);
            n_in     = add_sum[KW-1:0];
            d_in     = FirstDiv;
            sq_in    = FirstSq;
            tgt_in   = 1'b0;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (sq_ff > n_ff) begin
               if (!tgt_ff) begin
                  s_in     = n_ff[SW-1:0];
                  h_in     = '0;
                  state_in = ST_H;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            add_a = AW'(sq_ff);
            add_b = AW'({d_ff, 1'b1});
            if (div_rsp.done) begin
               if (div_rsp.remainder == '0) begin
                  n_in  = n_ff + 1'b1;
                  d_in  = FirstDiv;
                  sq_in = FirstSq;
               end else begin
                  sq_in = add_sum[KW-1:0];
                  d_in  = d_ff + 1'b1;
               end
               state_in = ST_CHK;
            end
         end
         ST_H: begin
            add_a = AW'(k_ff);
            add_b = AW'(s_ff);
            if (AW'(central_binom(h_ff)) >= add_sum) begin
               state_in = ST_LS;
            end else begin
               h_in = h_inc[HW-1:0];
            end
         end
         ST_LS: begin
            add_a    = AW'(k_ff);
            add_b    = AW'({1'b0, s_ff} + {4'd0, h_ff});
            l_in     = add_sum[KW-1:0];
            n_in     = add_sum[KW-1:0];
            d_in     = FirstDiv;
            sq_in    = FirstSq;
            tgt_in   = 1'b1;
            state_in = ST_CHK;
         end
         ST_DONE: begin
            if (!ov_ff || !rsp_stall) begin
               ov_in    = 1'b1;
               ox_in    = x_ff;
               os_in    = s_ff;
               oh_in    = h_ff;
               ow_in    = h_inc[WW:1];
               ol_in    = l_ff;
               olp_in   = n_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
      k_ff   <= k_in;
      x_ff   <= x_in;
      p_ff   <= p_in;
      q_ff   <= q_in;
      m_ff   <= m_in;
      n_ff   <= n_in;
      d_ff   <= d_in;
      sq_ff  <= sq_in;
      tgt_ff <= tgt_in;
      s_ff   <= s_in;
      h_ff   <= h_in;
      l_ff   <= l_in;
      ox_ff  <= ox_in;
      os_ff  <= os_in;
      oh_ff  <= oh_in;
      ow_ff  <= ow_in;
      ol_ff  <= ol_in;
      olp_ff <= olp_in;
   end

   assign req_stall              = (state_ff != ST_IDLE);
   assign rsp_valid              = ov_ff;
   assign rsp_x_value            = ox_ff;
   assign rsp_ldpc_count         = os_ff;
   assign rsp_half_count         = oh_ff;
   assign rsp_half_weight        = ow_ff;
   assign rsp_intermediate_count = ol_ff;
   assign rsp_intermediate_prime = olp_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted item did not start the sequencer");

   a_rem_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("remainder result arrived outside a trial division");

   a_prime_not_below: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_intermediate_prime >= rsp_intermediate_count)
      else $error("L prime below L");

   a_half_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_half_count <= 5'd16 && rsp_ldpc_count <= 8'd211)
      else $error("H or S out of range");

endmodule

>>> sim/tb_raptor_code_parameter_derivation_core.sv
`timescale 1ns / 1ps

module tb_raptor_code_parameter_derivation_core;
   import rcpd_pkg::*;

   localparam int unsigned MAX_SOURCE  = 8192;
   localparam int unsigned QUIET_LIMIT = 100000;
   localparam int unsigned RANDOM_ITEMS = 118;

   typedef struct packed {
      logic [XW-1:0] x_value;
      logic [SW-1:0] ldpc_count;
      logic [HW-1:0] half_count;
      logic [WW-1:0] half_weight;
      logic [KW-1:0] intermediate_count;
      logic [KW-1:0] intermediate_prime;
   } raptor_params_type;

   class raptor_scoreboard;
      raptor_params_type derived_q[$];
      int unsigned    mismatches;

      function new();
         mismatches = 0;
      endfunction

      // trial division up to floor(sqrt(n)); 0 and 1 pass
      function bit trial_prime(int unsigned n);
         for (int unsigned d = 2; d * d <= n; d++) begin
            if (n % d == 0) return 1'b0;
         end
         return 1'b1;
      endfunction

      function longint unsigned central_choose(int unsigned h);
         longint unsigned r;
         int unsigned     half;
         r    = 1;
         half = (h + 1) / 2;
         for (int unsigned i = 1; i <= half; i++) begin
            r = r * (h - half + i) / i;
         end
         return r;
      endfunction

      function raptor_params_type derive_params(logic [KW-1:0] count);
         raptor_params_type p;
         int unsigned    k, x, s, h, l, lp;
         k = count;
         if (k > MAX_SOURCE) k = MAX_SOURCE;
         x = 0;
         while (x * (x - 1) < 2 * k) x++;
         s = (k + 99) / 100 + x;
         while (!trial_prime(s)) s++;
         h = 0;
         while (central_choose(h) < longint'(k + s)) h++;
         l  = k + s + h;
         lp = l;
         while (!trial_prime(lp)) lp++;
         p.x_value            = XW'(x);
         p.ldpc_count         = SW'(s);
         p.half_count         = HW'(h);
         p.half_weight        = WW'((h + 1) / 2);
         p.intermediate_count = KW'(l);
         p.intermediate_prime = KW'(lp);
         return p;
      endfunction

      function void note_source(logic [KW-1:0] count);
         derived_q.push_back(derive_params(count));
      endfunction

      function int unsigned outstanding();
         return derived_q.size();
      endfunction

      task report(string what, int unsigned got, int unsigned want);
         $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
         mismatches++;
      endtask

      task check_result(raptor_params_type got);
         raptor_params_type want;
         if (derived_q.size() == 0) begin
            report("result with no item pending", got.x_value, 0);
            return;
         end
         want = derived_q.pop_front();
         if (got.x_value != want.x_value)
            report("x_value", got.x_value, want.x_value);
         if (got.ldpc_count != want.ldpc_count)
            report("ldpc_count", got.ldpc_count, want.ldpc_count);
         if (got.half_count != want.half_count)
            report("half_count", got.half_count, want.half_count);
         if (got.half_weight != want.half_weight)
            report("half_weight", got.half_weight, want.half_weight);
         if (got.intermediate_count != want.intermediate_count)
            report("intermediate_count", got.intermediate_count, want.intermediate_count);
         if (got.intermediate_prime != want.intermediate_prime)
            report("intermediate_prime", got.intermediate_prime, want.intermediate_prime);
      endtask
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [KW-1:0] req_source_count = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [XW-1:0] rsp_x_value;
   logic [SW-1:0] rsp_ldpc_count;
   logic [HW-1:0] rsp_half_count;
   logic [WW-1:0] rsp_half_weight;
   logic [KW-1:0] rsp_intermediate_count;
   logic [KW-1:0] rsp_intermediate_prime;

   logic          calm = 1'b0;
   int unsigned   quiet_cycles = 0;
   raptor_scoreboard sb;

   raptor_code_parameter_derivation_core #(
      .MAX_SOURCE(MAX_SOURCE)
   ) dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_source_count      (req_source_count),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_x_value           (rsp_x_value),
      .rsp_ldpc_count        (rsp_ldpc_count),
      .rsp_half_count        (rsp_half_count),
      .rsp_half_weight       (rsp_half_weight),
      .rsp_intermediate_count(rsp_intermediate_count),
      .rsp_intermediate_prime(rsp_intermediate_prime)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 36);
   end

   always @(posedge clock) begin : rsp_monitor
      raptor_params_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.x_value            = rsp_x_value;
         got.ldpc_count         = rsp_ldpc_count;
         got.half_count         = rsp_half_count;
         got.half_weight        = rsp_half_weight;
         got.intermediate_count = rsp_intermediate_count;
         got.intermediate_prime = rsp_intermediate_prime;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // leaves the item on the bus at the accepting edge
   task send_source(input logic [KW-1:0] count);
      while (!calm && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_source_count <= count;
      do @(posedge clock); while (req_stall);
      sb.note_source(count);
   endtask

   task send_random_source();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 70)
         send_source(KW'($urandom_range(0, 600)));
      else if (sel < 92)
         send_source(KW'($urandom_range(0, MAX_SOURCE)));
      else
         send_source(KW'($urandom_range(MAX_SOURCE + 1, (1 << KW) - 1)));
   endtask

   initial begin : stimulus
      logic [KW-1:0] directed_k[$];
      directed_k = '{0, 1, 2, 3, 4, 5, 6, 7, 10, 99, 100, 101, 1000, 4095, 4096,
                     5000, 5461, 8190, 8191, 8192, 8193, 10000, 10922, 16383};
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_k[i]) send_source(directed_k[i]);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 40) calm <= 1'b1;
         if (i == 80) calm <= 1'b0;
         send_random_source();
      end
      req_valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      if (sb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
design/rcpd_pkg.sv
design/rcpd_rem_unit.sv
design/raptor_code_parameter_derivation_core.sv
sim/tb_raptor_code_parameter_derivation_core.sv
